### hdl/lru_block_cache_core_macros.svh
// Assertion macros shared by the block cache RTL.
`ifndef LRU_BLOCK_CACHE_CORE_MACROS_SVH
`define LRU_BLOCK_CACHE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define LBC_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("lbc assertion failed");
`define LBC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbc assertion failed");
`else
`define LBC_ASSERT(lbl, cond)
`define LBC_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

### hdl/lbc_pkg.sv
// Shared types and constants of the block cache.
package lbc_pkg;
	localparam int MAX_ENTRIES     = 64;
	localparam int WORDS_PER_BLOCK = 32;
	localparam int SLOT_W          = $clog2(MAX_ENTRIES);
	localparam int CNT_W           = SLOT_W + 1;
	localparam int WORD_W          = $clog2(WORDS_PER_BLOCK);
	localparam int WI_W            = WORD_W + 1;
	localparam int ADDR_W          = SLOT_W + WORD_W;
	localparam int DISK_LIMIT      = 16;
	localparam int BLOCK_LIMIT     = 256;
	localparam int MIN_ENTRIES     = 2;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;
	localparam logic [1:0] OP_FLUSH  = 2'd3;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_REJ  = 2'd2;

	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_OPEN = 2'd1;
	localparam logic [1:0] PEND_REJ  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DECODE, ST_SCAN, ST_RD, ST_WT, ST_RESP
	} state_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic              live;
		logic [4:0]        disk;
		logic [8:0]        blk;
		logic              hit;
		logic [SLOT_W-1:0] hit_idx;
		logic              free;
		logic [SLOT_W-1:0] free_idx;
		logic              min_ok;
		logic [31:0]       min_stamp;
		logic [SLOT_W-1:0] min_idx;
	} sweep_t;

	// broadcast write to the slot cells
	typedef struct packed {
		logic              flush;
		logic              en;
		logic [SLOT_W-1:0] idx;
		logic              tag;
		logic [4:0]        disk;
		logic [8:0]        blk;
		logic              stamp_en;
		logic [31:0]       stamp;
	} slot_wr_t;
endpackage

### hdl/lbc_req_if.sv
// Request channel carrying one cache command per beat.
interface lbc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [4:0]  disk_number;
	logic [8:0]  block_number;
	logic [4:0]  word_index;
	logic [63:0] data_word;
	modport source (output valid, opcode, disk_number, block_number, word_index,
		data_word, input ready);
	modport sink (input valid, opcode, disk_number, block_number, word_index,
		data_word, output ready);
endinterface

### hdl/lbc_rsp_if.sv
// Response channel carrying one result per beat.
interface lbc_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] read_word;
	logic [4:0]  read_index;
	logic        last_result;
	logic [31:0] queries_seen;
	logic [31:0] hits_seen;
	modport source (output valid, status, read_word, read_index, last_result,
		queries_seen, hits_seen, input ready);
	modport sink (input valid, status, read_word, read_index, last_result,
		queries_seen, hits_seen, output ready);
endinterface

### hdl/lbc_cell.sv
// One cache slot: tag, valid and stamp, plus one stage of the search chain.
module lbc_cell import lbc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SLOT_W-1:0] cell_idx,
	input  logic              active,
	input  slot_wr_t          wr,
	input  sweep_t            sw_in,
	output sweep_t            sw_out
);
	logic        valid_q;
	logic [4:0]  disk_q;
	logic [8:0]  blk_q;
	logic [31:0] stamp_q;
	sweep_t      nxt;

	always_comb begin
		nxt = sw_in;
		if (active && sw_in.live) begin
			if (valid_q && !sw_in.hit && disk_q == sw_in.disk && blk_q == sw_in.blk) begin
				nxt.hit     = 1'b1;
				nxt.hit_idx = cell_idx;
			end
			if (!valid_q && !sw_in.free) begin
				nxt.free     = 1'b1;
				nxt.free_idx = cell_idx;
			end
			// strict compare keeps the lowest slot on ties
			if (!sw_in.min_ok || stamp_q < sw_in.min_stamp) begin
				nxt.min_ok    = 1'b1;
				nxt.min_stamp = stamp_q;
				nxt.min_idx   = cell_idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			disk_q  <= '0;
			blk_q   <= '0;
			stamp_q <= '0;
		end else if (wr.flush) begin
			valid_q <= 1'b0;
			disk_q  <= '0;
			blk_q   <= '0;
			stamp_q <= '0;
		end else if (wr.en && wr.idx == cell_idx) begin
			if (wr.tag) begin
				valid_q <= 1'b1;
				disk_q  <= wr.disk;
				blk_q   <= wr.blk;
			end
			if (wr.stamp_en) stamp_q <= wr.stamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_out <= '0;
		end else begin
			sw_out <= nxt;
		end
	end
endmodule

### hdl/lru_block_cache_core.sv
// Top level of the fully associative LRU block cache.
// Each command is taken one at a time. Flush, insert words past word 0 and a
// lookup before any insert are answered without a search. A lookup, update or
// insert word 0 sends a search token down the chain of MAX_ENTRIES slot cells,
// one cell per cycle. A lookup hit then streams WORDS_PER_BLOCK words from the
// block store, reading each through its registered read port and stalling
// while the output register is full. Results leave
// through an output register, so one result may wait while the next is formed.
`include "lru_block_cache_core_macros.svh"
module lru_block_cache_core import lbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	lbc_req_if.sink     req,
	lbc_rsp_if.source   rsp
);
	state_t state_q, state_d;

	logic [1:0]  op_q;
	logic [4:0]  disk_q;
	logic [8:0]  blk_q;
	logic [4:0]  widx_q;
	logic [63:0] data_q;

	logic [CNT_W-1:0]  entries_q;
	logic [CNT_W-1:0]  n_act;
	logic [31:0]       clock_q, clock_d, qry_q, qry_d, hit_q, hit_d;
	logic              any_q, any_d;
	logic [SLOT_W-1:0] pslot_q, pslot_d, mslot_q, mslot_d, vslot;
	logic [1:0]        pend_q, pend_d, res_q, res_d;
	logic [WORD_W-1:0] k_q, k_d;

	logic              out_vld_q, out_load;
	logic [1:0]        o_stat_q, o_stat_d;
	logic [63:0]       o_word_q, o_word_d;
	logic [4:0]        o_idx_q, o_idx_d;
	logic              o_last_q, o_last_d;
	logic [31:0]       o_qry_q, o_hit_q;

	logic [63:0]       mem [2**ADDR_W];
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr, rd_addr;
	logic [63:0]       rd_data_q;

	slot_wr_t wr;
	sweep_t   inject;
	sweep_t   link [MAX_ENTRIES+1];
	logic     start;
	logic     out_free;

	assign n_act = (entries_q < CNT_W'(MIN_ENTRIES)) ? CNT_W'(MIN_ENTRIES) :
		(entries_q > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : entries_q;

	always_comb begin
		inject           = '0;
		inject.live      = start;
		inject.disk      = disk_q;
		inject.blk       = blk_q;
		inject.min_stamp = '1;
	end
	assign link[0] = inject;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		lbc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (SLOT_W'(i)),
			.active   (CNT_W'(i) < n_act),
			.wr       (wr),
			.sw_in    (link[i]),
			.sw_out   (link[i+1])
		);
	end

	assign req.ready = (state_q == ST_IDLE);
	assign out_free  = !out_vld_q || rsp.ready;
	assign rd_addr   = {mslot_q, k_q};
	assign vslot     = link[MAX_ENTRIES].free ? link[MAX_ENTRIES].free_idx :
		link[MAX_ENTRIES].min_idx;

	always_comb begin
		state_d   = state_q;
		clock_d   = clock_q;
		qry_d     = qry_q;
		hit_d     = hit_q;
		any_d     = any_q;
		pslot_d   = pslot_q;
		pend_d    = pend_q;
		res_d     = res_q;
		mslot_d   = mslot_q;
		k_d       = k_q;
		start     = 1'b0;
		wr        = '0;
		wr.disk   = disk_q;
		wr.blk    = blk_q;
		wr.stamp  = clock_q + 32'd1;
		mem_we    = 1'b0;
		mem_waddr = {pslot_q, widx_q[WORD_W-1:0]};
		out_load  = 1'b0;
		o_stat_d  = res_q;
		o_word_d  = '0;
		o_idx_d   = '0;
		o_last_d  = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				state_d = ST_RESP;
				unique case (op_q)
					OP_LOOKUP: begin
						if (!any_q) begin
							res_d = STAT_MISS;
						end else begin
							qry_d   = qry_q + 32'd1;
							start   = 1'b1;
							state_d = ST_SCAN;
						end
					end
					OP_INSERT: begin
						if ({1'b0, widx_q} >= WI_W'(WORDS_PER_BLOCK)) begin
							res_d = STAT_REJ;
						end else if (widx_q != '0) begin
							if (pend_q != PEND_OPEN) begin
								res_d = STAT_REJ;
							end else begin
								mem_we = 1'b1;
								res_d  = STAT_OK;
							end
						end else if (disk_q > 5'(DISK_LIMIT) || blk_q > 9'(BLOCK_LIMIT)) begin
							pend_d = PEND_REJ;
							res_d  = STAT_REJ;
						end else begin
							any_d   = 1'b1;
							start   = 1'b1;
							state_d = ST_SCAN;
						end
					end
					OP_UPDATE: begin
						if ({1'b0, widx_q} >= WI_W'(WORDS_PER_BLOCK)) begin
							res_d = STAT_REJ;
						end else begin
							start   = 1'b1;
							state_d = ST_SCAN;
						end
					end
					OP_FLUSH: begin
						wr.flush = 1'b1;
						clock_d  = '0;
						any_d    = 1'b0;
						pslot_d  = '0;
						pend_d   = PEND_NONE;
						res_d    = STAT_OK;
					end
					default: ;
				endcase
			end
			ST_SCAN: begin
				if (link[MAX_ENTRIES].live) begin
					state_d = ST_RESP;
					wr.idx  = link[MAX_ENTRIES].hit_idx;
					case (op_q)
						OP_LOOKUP: begin
							if (!link[MAX_ENTRIES].hit) begin
								res_d = STAT_MISS;
							end else begin
								hit_d       = hit_q + 32'd1;
								clock_d     = clock_q + 32'd1;
								wr.en       = 1'b1;
								wr.stamp_en = 1'b1;
								mslot_d     = link[MAX_ENTRIES].hit_idx;
								k_d         = '0;
								state_d     = ST_RD;
							end
						end
						OP_INSERT: begin
							if (link[MAX_ENTRIES].hit) begin
								pend_d = PEND_REJ;
								res_d  = STAT_REJ;
							end else begin
								wr.en       = 1'b1;
								wr.idx      = vslot;
								wr.tag      = 1'b1;
								wr.stamp_en = 1'b1;
								clock_d     = clock_q + 32'd1;
								mem_we      = 1'b1;
								mem_waddr   = {vslot, {WORD_W{1'b0}}};
								pslot_d     = vslot;
								pend_d      = PEND_OPEN;
								res_d       = STAT_OK;
							end
						end
						default: begin
							if (!link[MAX_ENTRIES].hit) begin
								res_d = STAT_MISS;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = {link[MAX_ENTRIES].hit_idx, widx_q[WORD_W-1:0]};
								res_d     = STAT_OK;
								if (widx_q == '0) begin
									wr.en       = 1'b1;
									wr.stamp_en = 1'b1;
									clock_d     = clock_q + 32'd1;
								end
							end
						end
					endcase
				end
			end
			ST_RD: begin
				state_d = ST_WT;
			end
			ST_WT: begin
				if (out_free) begin
					out_load = 1'b1;
					o_stat_d = STAT_OK;
					o_word_d = rd_data_q;
					o_idx_d  = 5'(k_q);
					o_last_d = (k_q == WORD_W'(WORDS_PER_BLOCK - 1));
					if (o_last_d) begin
						state_d = ST_IDLE;
					end else begin
						k_d     = k_q + 1'b1;
						state_d = ST_RD;
					end
				end
			end
			ST_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			entries_q <= CNT_W'(MAX_ENTRIES);
			clock_q   <= '0;
			qry_q     <= '0;
			hit_q     <= '0;
			any_q     <= 1'b0;
			pslot_q   <= '0;
			pend_q    <= PEND_NONE;
			res_q     <= STAT_OK;
			mslot_q   <= '0;
			k_q       <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) entries_q <= cfg_wdata;
			clock_q <= clock_d;
			qry_q   <= qry_d;
			hit_q   <= hit_d;
			any_q   <= any_d;
			pslot_q <= pslot_d;
			pend_q  <= pend_d;
			res_q   <= res_d;
			mslot_q <= mslot_d;
			k_q     <= k_d;
			if (out_load) out_vld_q <= 1'b1;
			else if (rsp.ready) out_vld_q <= 1'b0;
		end
	end

	// capture the command beat and the result payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q   <= req.opcode;
			disk_q <= req.disk_number;
			blk_q  <= req.block_number;
			widx_q <= req.word_index;
			data_q <= req.data_word;
		end
		if (out_load) begin
			o_stat_q <= o_stat_d;
			o_word_q <= o_word_d;
			o_idx_q  <= o_idx_d;
			o_last_q <= o_last_d;
			o_qry_q  <= qry_q;
			o_hit_q  <= hit_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= data_q;
		rd_data_q <= mem[rd_addr];
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.status       = o_stat_q;
	assign rsp.read_word    = o_word_q;
	assign rsp.read_index   = o_idx_q;
	assign rsp.last_result  = o_last_q;
	assign rsp.queries_seen = o_qry_q;
	assign rsp.hits_seen    = o_hit_q;

	`LBC_ASSERT_IMP(a_idle_no_token, state_q == ST_IDLE, !link[MAX_ENTRIES].live)
	`LBC_ASSERT_IMP(a_stream_ok, out_vld_q && !o_last_q, o_stat_q == STAT_OK)
	`LBC_ASSERT_IMP(a_open_inserted, pend_q == PEND_OPEN, any_q)
endmodule
